// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level RTL file of the clock face LED driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that prop holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that cond is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/cfled_pkg.sv -----
// Shared types, codes and helper functions of the clock face LED driver.
`default_nettype none

package cfled_pkg;

  // Widest frame store address, enough for the largest ring.
  localparam int ADDR_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 8;
  localparam int LATCH_W    = 16;
  localparam int BIT_W      = 5;
  localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

  // Every stored byte is either all zero or all one, so one flag per color
  // byte stands for the whole 24-bit green-red-blue word.
  typedef logic [2:0] word_t;
  localparam word_t WORD_G     = 3'b100;
  localparam word_t WORD_R     = 3'b010;
  localparam word_t WORD_B     = 3'b001;
  localparam word_t WORD_WHITE = 3'b111;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PAINT = 3'd2,
    OP_MARK  = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    COLOR_BLACK = 3'd0,
    COLOR_RED   = 3'd1,
    COLOR_GREEN = 3'd2,
    COLOR_BLUE  = 3'd3,
    COLOR_WHITE = 3'd4
  } color_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ZERO_LOW  = 3'd1,
    CFG_ONE_HIGH  = 3'd2,
    CFG_ONE_LOW   = 3'd3,
    CFG_LATCH     = 3'd4
  } cfg_idx_e;

  // Request to the frame store for one clock cycle.
  typedef struct packed {
    logic              clear;
    logic              paint;
    word_t             mask;
    logic [ADDR_W-1:0] addr;
  } st_req_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
  } res_t;

  function automatic word_t color_mask(input logic [2:0] code);
    word_t m;
    case (code)
      COLOR_BLACK: m = '0;
      COLOR_RED:   m = WORD_R;
      COLOR_GREEN: m = WORD_G;
      COLOR_BLUE:  m = WORD_B;
      COLOR_WHITE: m = WORD_WHITE;
      default:     m = '0;
    endcase
    return m;
  endfunction

  // Hour modulo twelve by two conditional subtractions.
  function automatic logic [3:0] hour_pos(input logic [4:0] hour);
    logic [4:0] h;
    h = hour;
    if (h >= 5'd12) h = h - 5'd12;
    if (h >= 5'd12) h = h - 5'd12;
    return h[3:0];
  endfunction

  // (value / 5) mod 12 for values below 64: 13/64 is close enough to 1/5.
  function automatic logic [3:0] fifth_pos(input logic [5:0] value);
    logic [9:0] prod;
    prod = 10'(value) * 10'd13;
    if (prod[9:6] == 4'd12) return 4'd0;
    return prod[9:6];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cfled_if.sv -----
// Command and result channel interfaces of the clock face LED driver.
`default_nettype none

interface cfled_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [3:0] led_index;
  logic [2:0] color_code;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;

  modport source (
    output valid, opcode, led_index, color_code, hour, minute, second,
    input  ready
  );
  modport sink (
    input  valid, opcode, led_index, color_code, hour, minute, second,
    output ready
  );
endinterface

interface cfled_res_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, pin_level, busy_res, frame_done, input ready);
  modport sink (input valid, pin_level, busy_res, frame_done, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfled_store.sv -----
// Frame store: synchronous memory with read-modify-write, forwarding and row flags.
`default_nettype none

module cfled_store #(
  parameter int NUM_LEDS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfled_pkg::st_req_t req_i,
  output cfled_pkg::word_t   word_o
);
  import cfled_pkg::*;

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [ADDR_W:0] DEPTH = (ADDR_W + 1)'(NUM_LEDS);

  word_t               mem_q [NUM_LEDS];
  word_t               rd_q;
  word_t               fwd_word_q;
  word_t               wr_mask_q;
  word_t               wr_data;
  logic [AW-1:0]       rd_idx;
  logic [AW-1:0]       wr_addr_q;
  logic                rd_ok;
  logic                wr_pend_q;
  logic                fwd_q;
  logic                vld_q;
  logic [NUM_LEDS-1:0] valid_q;

  assign rd_idx = req_i.addr[AW-1:0];
  assign rd_ok  = {1'b0, req_i.addr} < DEPTH;

  // A row that was never written since the last clear reads as black.
  assign word_o  = fwd_q ? fwd_word_q : (vld_q ? rd_q : '0);
  assign wr_data = word_o | wr_mask_q;

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= wr_data;
    end
    rd_q <= mem_q[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    fwd_word_q <= wr_data;
    if (req_i.paint) begin
      wr_addr_q <= rd_idx;
      wr_mask_q <= req_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      fwd_q     <= 1'b0;
      vld_q     <= 1'b0;
      valid_q   <= '0;
    end else begin
      wr_pend_q <= req_i.paint;
      // The write landing at this edge is not yet visible to the read.
      fwd_q     <= wr_pend_q && !req_i.clear && (wr_addr_q == rd_idx);
      vld_q     <= rd_ok && valid_q[rd_idx];
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (wr_pend_q) begin
        valid_q[wr_addr_q] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/clock_face_led_strip_driver.sv -----
// Top level of the clock face LED driver: command decode, serial waveform, result queue.
// Results: the result of each transaction is registered in a two-slot queue and offered on the result channel.
// Throughput: one transaction per cycle while the result queue has a free slot; a mark time command holds
// the command channel for its blue and green writes, as its three positions share the single frame store write port.
// Reset: control and configuration registers return to their defaults and the frame store
// reads as all black at once through one valid flag per LED; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module clock_face_led_strip_driver #(
  parameter int NUM_LEDS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cfled_cmd_if.sink                           cmd_i,
  cfled_res_if.source                         res_o,
  input  logic                                cfg_we_i,
  input  logic [cfled_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cfled_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import cfled_pkg::*;

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [ADDR_W:0] DEPTH    = (ADDR_W + 1)'(NUM_LEDS);
  localparam logic [AW-1:0]   LAST_LED = AW'(NUM_LEDS - 1);
  localparam logic [1:0]      CNT_FULL = 2'd2;

  // Waveform phase of the bit being sent, or the latch interval at frame end.
  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_LATCH = 2'd2
  } phase_e;

  // Remaining frame store writes of a mark time command.
  typedef enum logic [1:0] {
    MT_IDLE  = 2'd0,
    MT_BLUE  = 2'd1,
    MT_GREEN = 2'd2
  } mt_e;

  // Timing registers, written through the configuration port.
  logic [TICK_W-1:0]  zero_high_q;
  logic [TICK_W-1:0]  zero_low_q;
  logic [TICK_W-1:0]  one_high_q;
  logic [TICK_W-1:0]  one_low_q;
  logic [LATCH_W-1:0] latch_q;

  // Sender state.
  logic               sending_q, sending_d;
  phase_e             phase_q, phase_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [AW-1:0]      led_q, led_d;
  logic [AW-1:0]      led_nx;
  logic [LATCH_W-1:0] tick_q, tick_d;
  logic [LATCH_W-1:0] tick_n;
  logic               use_rd_q, use_rd_d;
  word_t              cur_word_q;
  word_t              word;
  logic               cur_bit;
  logic [TICK_W-1:0]  len_hi;
  logic [TICK_W-1:0]  len_lo;

  // Mark time sequencing.
  mt_e                mt_q, mt_d;
  logic [3:0]         mt_blue_q, mt_green_q;
  logic               mt_blue_ok_q, mt_green_ok_q;
  logic [3:0]         red_pos, blue_pos, green_pos;
  logic               red_ok, blue_ok, green_ok, paint_ok;
  word_t              paint_mask;

  // Frame store and result queue.
  st_req_t            st_req;
  word_t              st_word;
  res_t               res_new;
  res_t               slot0_q, slot1_q;
  logic [1:0]         cnt_q, cnt_d;
  logic               acc, push, pop;

  cfled_store #(
    .NUM_LEDS (NUM_LEDS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .word_o (st_word)
  );

  // The command channel is taken while the queue has a free slot and no mark time writes
  // remain, so a new transaction is accepted even while an earlier result waits downstream.
  assign cmd_i.ready = (cnt_q != CNT_FULL) && (mt_q == MT_IDLE);
  assign acc  = cmd_i.valid && cmd_i.ready;
  assign push = acc;
  assign pop  = res_o.valid && res_o.ready;

  assign res_o.valid      = (cnt_q != 2'd0);
  assign res_o.pin_level  = slot0_q.pin_level;
  assign res_o.busy_res   = slot0_q.busy_res;
  assign res_o.frame_done = slot0_q.frame_done;

  // Clock face positions and range checks for the paint commands.
  assign red_pos    = hour_pos(cmd_i.hour);
  assign blue_pos   = fifth_pos(cmd_i.minute);
  assign green_pos  = fifth_pos(cmd_i.second);
  assign red_ok     = {5'd0, red_pos} < DEPTH;
  assign blue_ok    = {5'd0, blue_pos} < DEPTH;
  assign green_ok   = {5'd0, green_pos} < DEPTH;
  assign paint_mask = color_mask(cmd_i.color_code);
  assign paint_ok   = ({5'd0, cmd_i.led_index} < DEPTH) && (paint_mask != '0);

  // The word of a new LED arrives from the store in the cycle after its read;
  // from then on the sender works from its own copy.
  assign word = use_rd_q ? st_word : cur_word_q;

  // Bits go out most significant first: green byte, then red, then blue.
  always_comb begin
    if (bit_q inside {[5'd0:5'd7]}) begin
      cur_bit = word[2];
    end else if (bit_q inside {[5'd8:5'd15]}) begin
      cur_bit = word[1];
    end else begin
      cur_bit = word[0];
    end
  end

  assign len_hi = cur_bit ? one_high_q : zero_high_q;
  assign len_lo = cur_bit ? one_low_q : zero_low_q;
  assign tick_n = tick_q + 16'd1;
  assign led_nx = led_q + AW'(1);

  always_comb begin
    sending_d = sending_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    led_d     = led_q;
    tick_d    = tick_q;
    use_rd_d  = 1'b0;
    mt_d      = mt_q;
    res_new   = '0;
    st_req    = '0;

    // The second and third writes of a mark time command.
    case (mt_q)
      MT_BLUE: begin
        st_req.addr  = ADDR_W'(mt_blue_q);
        st_req.paint = mt_blue_ok_q;
        st_req.mask  = WORD_B;
        mt_d         = MT_GREEN;
      end
      MT_GREEN: begin
        st_req.addr  = ADDR_W'(mt_green_q);
        st_req.paint = mt_green_ok_q;
        st_req.mask  = WORD_G;
        mt_d         = MT_IDLE;
      end
      default: ;
    endcase

    if (acc) begin
      if (sending_q) begin
        res_new.busy_res = 1'b1;
        if (cmd_i.opcode == OP_TICK) begin
          case (phase_q)
            PH_HIGH: begin
              res_new.pin_level = 1'b1;
              if (tick_n >= {8'd0, len_hi}) begin
                tick_d  = '0;
                phase_d = PH_LOW;
              end else begin
                tick_d = tick_n;
              end
            end
            PH_LOW: begin
              if (tick_n >= {8'd0, len_lo}) begin
                tick_d  = '0;
                phase_d = PH_HIGH;
                if (bit_q == LAST_BIT) begin
                  bit_d = '0;
                  if (led_q == LAST_LED) begin
                    phase_d = PH_LATCH;
                    led_d   = '0;
                  end else begin
                    // Fetch the next LED word; it is needed on the next tick.
                    led_d       = led_nx;
                    st_req.addr = ADDR_W'(led_nx);
                    use_rd_d    = 1'b1;
                  end
                end else begin
                  bit_d = bit_q + 5'd1;
                end
              end else begin
                tick_d = tick_n;
              end
            end
            default: begin
              // A zero latch length, or a count that wraps, also ends it.
              if (tick_n >= latch_q || tick_n == '0) begin
                res_new.frame_done = 1'b1;
                sending_d          = 1'b0;
                phase_d            = PH_HIGH;
                bit_d              = '0;
                led_d              = '0;
                tick_d             = '0;
              end else begin
                tick_d = tick_n;
              end
            end
          endcase
        end else begin
          // Commands are ignored during a frame; report the held level.
          res_new.pin_level = (phase_q == PH_HIGH);
        end
      end else begin
        case (cmd_i.opcode)
          OP_CLEAR: begin
            st_req.clear = 1'b1;
          end
          OP_PAINT: begin
            st_req.addr  = {4'd0, cmd_i.led_index};
            st_req.paint = paint_ok;
            st_req.mask  = paint_mask;
          end
          OP_MARK: begin
            st_req.addr  = {4'd0, red_pos};
            st_req.paint = red_ok;
            st_req.mask  = WORD_R;
            mt_d         = MT_BLUE;
          end
          OP_START: begin
            sending_d        = 1'b1;
            phase_d          = PH_HIGH;
            bit_d            = '0;
            led_d            = '0;
            tick_d           = '0;
            st_req.addr      = '0;
            use_rd_d         = 1'b1;
            res_new.busy_res = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Control state of the sender, the mark time sequence and the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      phase_q   <= PH_HIGH;
      bit_q     <= '0;
      led_q     <= '0;
      tick_q    <= '0;
      use_rd_q  <= 1'b0;
      mt_q      <= MT_IDLE;
      cnt_q     <= '0;
    end else begin
      sending_q <= sending_d;
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      led_q     <= led_d;
      tick_q    <= tick_d;
      use_rd_q  <= use_rd_d;
      mt_q      <= mt_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= 8'd8;
      zero_low_q  <= 8'd16;
      one_high_q  <= 8'd16;
      one_low_q   <= 8'd8;
      latch_q     <= 16'd2000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZERO_HIGH: zero_high_q <= cfg_wdata_i[TICK_W-1:0];
        CFG_ZERO_LOW:  zero_low_q  <= cfg_wdata_i[TICK_W-1:0];
        CFG_ONE_HIGH:  one_high_q  <= cfg_wdata_i[TICK_W-1:0];
        CFG_ONE_LOW:   one_low_q   <= cfg_wdata_i[TICK_W-1:0];
        CFG_LATCH:     latch_q     <= cfg_wdata_i[LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers: LED word copy, pending mark positions, queue slots.
  always_ff @(posedge clk_i) begin
    if (use_rd_q) begin
      cur_word_q <= st_word;
    end
    if (acc && !sending_q && cmd_i.opcode == OP_MARK) begin
      mt_blue_q     <= blue_pos;
      mt_green_q    <= green_pos;
      mt_blue_ok_q  <= blue_ok;
      mt_green_ok_q <= green_ok;
    end
    if (pop) begin
      slot0_q <= (cnt_q == CNT_FULL) ? slot1_q : res_new;
      if (push && cnt_q == CNT_FULL) begin
        slot1_q <= res_new;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= res_new;
      end else begin
        slot1_q <= res_new;
      end
    end
  end

  // A mark time command must hold off the next transaction.
  `ASSERT_PROP(a_mark_stalls, clk_i, rst_ni, (acc && !sending_q && cmd_i.opcode == OP_MARK) |=> !cmd_i.ready, "mark time did not stall the command channel")
  // The frame store is never changed while a frame goes out.
  `ASSERT_NEVER(a_no_write_sending, clk_i, rst_ni, sending_q && (st_req.paint || st_req.clear), "frame store written during a frame")
  // Bit phase counts stay within the eight-bit tick lengths.
  `ASSERT_NEVER(a_tick_range, clk_i, rst_ni, sending_q && phase_q != PH_LATCH && tick_q[15:8] != 8'd0, "bit phase tick count out of range")
  // A completed frame leaves the sender idle.
  `ASSERT_PROP(a_done_idle, clk_i, rst_ni, (push && res_new.frame_done) |=> !sending_q, "sender still busy after frame done")

endmodule

`default_nettype wire
